// ===== rtl/gibb_pkg.sv =====
// package: shared types and codes for the gf2 basis builder
package gibb_pkg;

  localparam int unsigned WordBits = 64;
  localparam int unsigned MaxWords = 5;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REDUCE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_XOR,
    ST_INS_WR,
    ST_RED_P,
    ST_RED_E,
    ST_RED_CHK,
    ST_RED_TST,
    ST_RED_LD,
    ST_RED_XOR,
    ST_RED_WB,
    ST_RD_WAIT,
    ST_DONE
  } gibb_state_e;

  typedef struct packed {
    logic load;
    logic shift;
  } gibb_ctrl_t;

endpackage

// ===== rtl/gf2_incremental_basis_builder_unit.sv =====
// top level: gf2 basis builder with word cell chain and row memory
// An item is taken when start is high and busy is low; its one result shows on the
// output ports for a single cycle with done_o high, and the receiver cannot stall it.
// A read fetches one word of a pivot row. An insert scans the columns in order,
// folds in the stored row at each set bit that already has a pivot, and stores the
// vector as a new row at the first set bit without one. A reduce walks every pair
// of pivot columns and folds the higher pivot row into each lower row that has that
// bit set. All of this goes through the single port row memory, one word at a time.
module gf2_incremental_basis_builder_unit #(
  parameter int unsigned VECTOR_BITS      = 320,
  parameter int unsigned WORDS_PER_VECTOR = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] vec_word0_i,
  input  logic [63:0] vec_word1_i,
  input  logic [63:0] vec_word2_i,
  input  logic [63:0] vec_word3_i,
  input  logic [63:0] vec_word4_i,
  input  logic [8:0]  read_column_i,
  input  logic [2:0]  read_word_i,
  output logic        done_o,
  output logic        independent_o,
  output logic [8:0]  new_pivot_o,
  output logic [8:0]  basis_rank_o,
  output logic        row_valid_o,
  output logic [63:0] row_data_o
);
  import gibb_pkg::*;

  localparam int unsigned W     = WORDS_PER_VECTOR;
  localparam int unsigned CW    = $clog2(VECTOR_BITS);
  localparam int unsigned CNTW  = $clog2(VECTOR_BITS + 1);
  localparam int unsigned DEPTH = VECTOR_BITS * W;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XW    = AW + CNTW;
  localparam int unsigned WCW   = $clog2(W + 1);

  function automatic logic [AW-1:0] row_addr(logic [CNTW-1:0] r, logic [CNTW-1:0] w);
    logic [XW-1:0] t;
    t = XW'(r) * XW'(W) + XW'(w);
    return t[AW-1:0];
  endfunction

  gibb_state_e state_q, state_d;
  logic [CNTW-1:0] col_q, col_d, e_q, e_d;
  logic [WCW-1:0] cnt_q, cnt_d;
  logic rd_vld_q, rd_vld_d;
  logic rd_use_q, rd_use_d;
  logic [VECTOR_BITS-1:0] piv_q;
  logic piv_set;
  logic [CW-1:0] piv_idx;
  logic [8:0] rank_q;
  logic res_ind_q, res_ind_d, res_val_q, res_val_d;
  logic [8:0] res_piv_q, res_piv_d;
  logic [63:0] res_data_q, res_data_d;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [63:0] ram_rdata;
  gibb_ctrl_t ctrl;
  logic keep, use_rd;
  logic [63:0] tail;
  logic [63:0] cell_w [W];
  logic [63:0] vec_in [MaxWords];
  logic [W*64-1:0] cand_flat;
  logic cand_bit, rc_ok, rw_ok;

  assign vec_in[0] = vec_word0_i;
  assign vec_in[1] = vec_word1_i;
  assign vec_in[2] = vec_word2_i;
  assign vec_in[3] = vec_word3_i;
  assign vec_in[4] = vec_word4_i;

  assign tail = (keep ? cell_w[0] : 64'd0) ^ (use_rd ? ram_rdata : 64'd0);

  for (genvar k = 0; k < W; k++) begin : g_cell
    logic [63:0] mask;
    logic [63:0] nxt;
    for (genvar b = 0; b < 64; b++) begin : g_mask
      assign mask[b] = ((k * 64 + b) < VECTOR_BITS) ? 1'b1 : 1'b0;
    end
    if (k == W - 1) begin : g_tail
      assign nxt = tail;
    end else begin : g_mid
      assign nxt = cell_w[k+1];
    end
    gibb_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .load_data_i(vec_in[k] & mask),
      .shift_in_i (nxt),
      .word_o     (cell_w[k])
    );
    assign cand_flat[k*64 +: 64] = cell_w[k];
  end

  assign cand_bit = cand_flat[col_q[CW-1:0]];
  assign rc_ok    = (read_column_i < VECTOR_BITS) && piv_q[read_column_i[CW-1:0]];
  assign rw_ok    = (read_word_i < W);

  gibb_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(cell_w[0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    e_d        = e_q;
    cnt_d      = cnt_q;
    rd_vld_d   = 1'b0;
    rd_use_d   = rd_use_q;
    res_ind_d  = res_ind_q;
    res_piv_d  = res_piv_q;
    res_val_d  = res_val_q;
    res_data_d = res_data_q;
    ram_we     = 1'b0;
    ram_addr   = '0;
    ctrl       = '0;
    keep       = 1'b1;
    use_rd     = 1'b0;
    piv_set    = 1'b0;
    piv_idx    = col_q[CW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          res_ind_d  = 1'b0;
          res_piv_d  = '0;
          res_val_d  = 1'b0;
          res_data_d = '0;
          case (req_type_i)
            REQ_INSERT: begin
              ctrl.load = 1'b1;
              col_d     = '0;
              state_d   = ST_INS_SCAN;
            end
            REQ_REDUCE: begin
              col_d   = CNTW'(VECTOR_BITS - 1);
              state_d = ST_RED_P;
            end
            REQ_READ: begin
              res_val_d = rc_ok;
              rd_use_d  = rc_ok && rw_ok;
              if (rc_ok && rw_ok) begin
                ram_addr = row_addr(CNTW'(read_column_i), CNTW'(read_word_i));
              end
              state_d = ST_RD_WAIT;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_INS_SCAN: begin
        cnt_d = '0;
        if (col_q == CNTW'(VECTOR_BITS)) begin
          state_d = ST_DONE;
        end else if (!cand_bit) begin
          col_d = col_q + 1'b1;
        end else if (piv_q[col_q[CW-1:0]]) begin
          state_d = ST_INS_XOR;
        end else begin
          state_d = ST_INS_WR;
        end
      end
      ST_INS_XOR, ST_RED_LD, ST_RED_XOR: begin
        keep   = (state_q != ST_RED_LD);
        use_rd = 1'b1;
        if (cnt_q != WCW'(W)) begin
          ram_addr = row_addr((state_q == ST_RED_LD) ? e_q : col_q, CNTW'(cnt_q));
          rd_vld_d = 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end
        if (rd_vld_q) begin
          ctrl.shift = 1'b1;
        end
        if (cnt_q == WCW'(W) && rd_vld_q) begin
          cnt_d = '0;
          case (state_q)
            ST_INS_XOR: begin
              col_d   = col_q + 1'b1;
              state_d = ST_INS_SCAN;
            end
            ST_RED_LD: state_d = ST_RED_XOR;
            default:   state_d = ST_RED_WB;
          endcase
        end
      end
      ST_INS_WR, ST_RED_WB: begin
        ram_we     = 1'b1;
        ram_addr   = row_addr((state_q == ST_RED_WB) ? e_q : col_q, CNTW'(cnt_q));
        ctrl.shift = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == WCW'(W - 1)) begin
          cnt_d = '0;
          if (state_q == ST_INS_WR) begin
            piv_set   = 1'b1;
            res_ind_d = 1'b1;
            res_piv_d = 9'(col_q);
            state_d   = ST_DONE;
          end else begin
            e_d     = e_q + 1'b1;
            state_d = ST_RED_E;
          end
        end
      end
      ST_RED_P: begin
        e_d = '0;
        if (piv_q[col_q[CW-1:0]] && col_q != '0) begin
          state_d = ST_RED_E;
        end else if (col_q == '0) begin
          state_d = ST_DONE;
        end else begin
          col_d = col_q - 1'b1;
        end
      end
      ST_RED_E: begin
        cnt_d = '0;
        if (e_q == col_q) begin
          if (col_q == '0) begin
            state_d = ST_DONE;
          end else begin
            col_d   = col_q - 1'b1;
            state_d = ST_RED_P;
          end
        end else if (piv_q[e_q[CW-1:0]]) begin
          state_d = ST_RED_CHK;
        end else begin
          e_d = e_q + 1'b1;
        end
      end
      ST_RED_CHK: begin
        ram_addr = row_addr(e_q, CNTW'(col_q >> 6));
        state_d  = ST_RED_TST;
      end
      ST_RED_TST: begin
        if (ram_rdata[col_q[5:0]]) begin
          state_d = ST_RED_LD;
        end else begin
          e_d     = e_q + 1'b1;
          state_d = ST_RED_E;
        end
      end
      ST_RD_WAIT: begin
        res_data_d = rd_use_q ? ram_rdata : 64'd0;
        state_d    = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      col_q    <= '0;
      e_q      <= '0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_use_q <= 1'b0;
      piv_q    <= '0;
      rank_q   <= '0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      e_q      <= e_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      rd_use_q <= rd_use_d;
      if (piv_set) begin
        piv_q[piv_idx] <= 1'b1;
        rank_q         <= rank_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_ind_q  <= res_ind_d;
    res_piv_q  <= res_piv_d;
    res_val_q  <= res_val_d;
    res_data_q <= res_data_d;
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = (state_q == ST_DONE);
  assign independent_o = res_ind_q;
  assign new_pivot_o   = res_piv_q;
  assign basis_rank_o  = rank_q;
  assign row_valid_o   = res_val_q;
  assign row_data_o    = res_data_q;

endmodule

// ===== rtl/gibb_ram.sv =====
// generic single port ram with registered read
module gibb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1600
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gibb_cell.sv =====
// one word cell of the rotating vector chain
module gibb_cell (
  input  logic                 clk_i,
  input  gibb_pkg::gibb_ctrl_t ctrl_i,
  input  logic [63:0]          load_data_i,
  input  logic [63:0]          shift_in_i,
  output logic [63:0]          word_o
);
  import gibb_pkg::*;

  logic [WordBits-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.load) begin
      word_d = load_data_i;
    end else if (ctrl_i.shift) begin
      word_d = shift_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ===== test/gf2_basis_checker.sv =====
// checker: predicts gf2 basis builder results and compares them with the outputs
`timescale 1ns / 1ps
module gf2_basis_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] vec_word0_i,
  input  logic [63:0] vec_word1_i,
  input  logic [63:0] vec_word2_i,
  input  logic [63:0] vec_word3_i,
  input  logic [63:0] vec_word4_i,
  input  logic [8:0]  read_column_i,
  input  logic [2:0]  read_word_i,
  input  logic        done_i,
  input  logic        independent_i,
  input  logic [8:0]  new_pivot_i,
  input  logic [8:0]  basis_rank_i,
  input  logic        row_valid_i,
  input  logic [63:0] row_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  import gibb_pkg::*;

  localparam int unsigned NumCols = 320;

  typedef struct packed {
    logic        independent;
    logic [8:0]  new_pivot;
    logic [8:0]  basis_rank;
    logic        row_valid;
    logic [63:0] row_data;
  } basis_result_t;

  logic [NumCols-1:0] basis_row [NumCols];
  logic [NumCols-1:0] pivot_held;
  logic [8:0]         rank_q;
  basis_result_t      expected_q [$];

  function automatic basis_result_t process_request(input logic [1:0] req,
                                                    input logic [NumCols-1:0] vin,
                                                    input logic [8:0] col,
                                                    input logic [2:0] wsel);
    basis_result_t r;
    logic [NumCols-1:0] cand;
    r = '0;
    cand = vin;
    if (req == REQ_INSERT) begin
      for (int c = 0; c < NumCols; c++) begin
        if (cand[c]) begin
          if (pivot_held[c]) begin
            cand ^= basis_row[c];
          end else begin
            basis_row[c] = cand;
            pivot_held[c] = 1'b1;
            rank_q = rank_q + 9'd1;
            r.independent = 1'b1;
            r.new_pivot = c[8:0];
            break;
          end
        end
      end
    end else if (req == REQ_REDUCE) begin
      for (int p = NumCols - 1; p >= 0; p--) begin
        if (pivot_held[p]) begin
          for (int e = 0; e < p; e++) begin
            if (pivot_held[e] && basis_row[e][p]) basis_row[e] ^= basis_row[p];
          end
        end
      end
    end else if (req == REQ_READ) begin
      if (col < NumCols && pivot_held[col]) begin
        r.row_valid = 1'b1;
        if (wsel < MaxWords) r.row_data = basis_row[col][wsel*WordBits +: WordBits];
      end
    end
    r.basis_rank = rank_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    basis_result_t got;
    basis_result_t want;
    if (!rst_ni) begin
      pivot_held = '0;
      rank_q = '0;
      fail_count_o <= 0;
    end else begin
      if (done_i) begin
        got = '{independent_i, new_pivot_i, basis_rank_i, row_valid_i, row_data_i};
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("result with no item pending: %p", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10) $display("mismatch: expected %p actual %p", want, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        want = process_request(req_type_i,
          {vec_word4_i, vec_word3_i, vec_word2_i, vec_word1_i, vec_word0_i},
          read_column_i, read_word_i);
        expected_q.insert(expected_q.size(), want);
      end
    end
  end

  assign pending_o = expected_q.size();

endmodule

// ===== test/tb_gf2_incremental_basis_builder_unit.sv =====
// testbench top: stimulus and verdict for the gf2 basis builder
`timescale 1ns / 1ps
module tb_gf2_incremental_basis_builder_unit;
  import gibb_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  req_type_i;
  logic [63:0] vec_word_i [5];
  logic [8:0]  read_column_i;
  logic [2:0]  read_word_i;
  logic        done_o;
  logic        independent_o;
  logic [8:0]  new_pivot_o;
  logic [8:0]  basis_rank_o;
  logic        row_valid_o;
  logic [63:0] row_data_o;
  int          fail_count;
  int          pending;
  logic [319:0] inserted_vecs [$];
  bit          no_gaps;

  gf2_incremental_basis_builder_unit u_top (
    .clk_i, .rst_ni, .start, .busy, .req_type_i,
    .vec_word0_i(vec_word_i[0]), .vec_word1_i(vec_word_i[1]), .vec_word2_i(vec_word_i[2]),
    .vec_word3_i(vec_word_i[3]), .vec_word4_i(vec_word_i[4]),
    .read_column_i, .read_word_i, .done_o, .independent_o, .new_pivot_o,
    .basis_rank_o, .row_valid_o, .row_data_o
  );

  gf2_basis_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .req_type_i,
    .vec_word0_i(vec_word_i[0]), .vec_word1_i(vec_word_i[1]), .vec_word2_i(vec_word_i[2]),
    .vec_word3_i(vec_word_i[3]), .vec_word4_i(vec_word_i[4]),
    .read_column_i, .read_word_i, .done_i(done_o), .independent_i(independent_o),
    .new_pivot_i(new_pivot_o), .basis_rank_i(basis_rank_o), .row_valid_i(row_valid_o),
    .row_data_i(row_data_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic send_item(input logic [1:0] req, input logic [319:0] vec,
                           input logic [8:0] col, input logic [2:0] wsel);
    int gap;
    start <= 1'b1;
    req_type_i <= req;
    for (int w = 0; w < 5; w++) vec_word_i[w] <= vec[w*64 +: 64];
    read_column_i <= col;
    read_word_i <= wsel;
    if (req == REQ_INSERT) inserted_vecs.insert(inserted_vecs.size(), vec);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [319:0] rand_vec();
    logic [319:0] v;
    for (int w = 0; w < 10; w++) v[w*32 +: 32] = $urandom;
    return v;
  endfunction

  function automatic logic [319:0] make_vec();
    logic [319:0] v;
    int sel;
    sel = $urandom_range(0, 9);
    v = '0;
    if (sel < 4) begin
      v = rand_vec();
    end else if (sel < 6) begin
      repeat ($urandom_range(1, 4)) v[$urandom_range(0, 319)] = 1'b1;
    end else if (sel < 8 && inserted_vecs.size() > 1) begin
      v = inserted_vecs[$urandom_range(0, inserted_vecs.size() - 1)] ^
          inserted_vecs[$urandom_range(0, inserted_vecs.size() - 1)];
    end else if (sel < 9) begin
      v = rand_vec() & ~((320'd1 << ($urandom_range(0, 4) * 64)) - 320'd1);
    end else if (inserted_vecs.size() > 0) begin
      v = inserted_vecs[$urandom_range(0, inserted_vecs.size() - 1)];
    end
    return v;
  endfunction

  initial begin
    int sel;
    rst_ni = 1'b0;
    start = 1'b0;
    req_type_i = REQ_INSERT;
    for (int w = 0; w < 5; w++) vec_word_i[w] = '0;
    read_column_i = '0;
    read_word_i = '0;
    no_gaps = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_item(REQ_REDUCE, '0, '0, '0);
    send_item(REQ_READ, '0, 9'd0, 3'd0);
    send_item(REQ_INSERT, '0, '0, '0);
    send_item(REQ_INSERT, 320'd1, '0, '0);
    send_item(REQ_INSERT, 320'd1 << 319, '0, '0);
    send_item(REQ_INSERT, '1, '0, '0);
    send_item(REQ_INSERT, '1, '0, '0);
    send_item(REQ_INSERT, 320'd3, '0, '0);
    for (int w = 0; w < 8; w++) send_item(REQ_READ, '0, 9'd0, w[2:0]);
    send_item(REQ_READ, '0, 9'd319, 3'd4);
    send_item(REQ_READ, '0, 9'd511, 3'd0);
    send_item(REQ_READ, '0, 9'd5, 3'd0);
    send_item(2'd3, '1, 9'd0, 3'd0);
    send_item(REQ_REDUCE, '0, '0, '0);
    send_item(REQ_READ, '0, 9'd0, 3'd0);
    send_item(REQ_READ, '0, 9'd1, 3'd4);

    // random
    for (int i = 0; i < 1200; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 399);
      if (sel == 0) begin
        send_item(REQ_REDUCE, rand_vec(), 9'($urandom), 3'($urandom));
      end else if (sel < 5) begin
        send_item(2'd3, rand_vec(), 9'($urandom), 3'($urandom));
      end else if (sel < 180) begin
        send_item(REQ_INSERT, make_vec(), 9'($urandom), 3'($urandom));
      end else if (sel < 380) begin
        send_item(REQ_READ, rand_vec(), 9'($urandom_range(0, 319)),
                  3'($urandom_range(0, 4)));
      end else begin
        send_item(REQ_READ, rand_vec(), 9'($urandom), 3'($urandom));
      end
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #300ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
